[rtl/detector_pixel_binner_top_macros.svh]
// Assertion macros for the detector pixel binner checker.
// No dependencies; included by the checker file.
`ifndef DETECTOR_PIXEL_BINNER_TOP_MACROS_SVH
`define DETECTOR_PIXEL_BINNER_TOP_MACROS_SVH

// checked outside reset
`define DPB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked during reset as well
`define DPB_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/dpb_pkg.sv]
// Shared types and constants for the detector pixel binner.
// No dependencies.
package dpb_pkg;

    typedef enum logic [1:0] {
        OP_MAP_WR = 2'd0,
        OP_CNT_WR = 2'd1,
        OP_SAMPLE = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_UPD,
        ST_DIV,
        ST_OUT
    } state_t;

    localparam logic [2:0] REG_AVG_MODE = 3'd0;
    localparam logic [2:0] REG_ID_MAP   = 3'd4;

    localparam int SUM_W     = 48;
    localparam int DIV_STEPS = 48;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef struct packed {
        logic        map_wr;
        logic [15:0] map_addr;
        logic [11:0] map_wdata;
        logic        cnt_wr;
        logic [15:0] cnt_addr;
        logic [12:0] cnt_wdata;
    } tbl_req_t;

    typedef struct packed {
        logic             wr;
        logic [15:0]      addr;
        logic             wflag;
        logic [SUM_W-1:0] wsum;
    } acc_req_t;

endpackage

[rtl/dpb_tables.sv]
// Pixel-to-bin map and per-bin pixel count memories.
// Depends on dpb_pkg.
module dpb_tables
    import dpb_pkg::*;
#(
    parameter int PIXELS = 4096,
    parameter int BINS   = 4096
)
(
    input  logic        clk,
    input  tbl_req_t    req,
    output logic [11:0] map_rdata,
    output logic [12:0] cnt_rdata
);

    localparam int PA = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int BA = (BINS > 1) ? $clog2(BINS) : 1;

    logic [11:0] map_mem [PIXELS];
    logic [12:0] cnt_mem [BINS];

    always_ff @(posedge clk)
    begin
        if (req.map_wr)
        begin
            map_mem[req.map_addr[PA-1:0]] <= req.map_wdata;
        end
        map_rdata <= map_mem[req.map_addr[PA-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (req.cnt_wr)
        begin
            cnt_mem[req.cnt_addr[BA-1:0]] <= req.cnt_wdata;
        end
        cnt_rdata <= cnt_mem[req.cnt_addr[BA-1:0]];
    end

endmodule

[rtl/dpb_accum.sv]
// Bin accumulator and flag memory with a clearing sweep after reset.
// Depends on dpb_pkg.
module dpb_accum
    import dpb_pkg::*;
#(
    parameter int BINS = 4096
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  acc_req_t         req,
    output logic             busy,
    output logic [SUM_W-1:0] rsum,
    output logic             rflag
);

    localparam int BA = (BINS > 1) ? $clog2(BINS) : 1;
    localparam logic [BA-1:0] LAST = BA'(BINS - 1);

    logic [SUM_W:0]  acc_mem [BINS];
    logic            busy_reg;
    logic [BA-1:0]   clr_reg;
    logic            busy_next;
    logic [BA-1:0]   clr_next;
    logic            wr_en;
    logic [BA-1:0]   wr_addr;
    logic [SUM_W:0]  wr_data;

    assign busy = busy_reg;

    always_comb
    begin
        busy_next = busy_reg;
        clr_next  = clr_reg;
        if (busy_reg)
        begin
            clr_next = clr_reg + 1'b1;
            if (clr_reg == LAST)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            clr_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            clr_reg  <= clr_next;
        end
    end

    always_comb
    begin
        wr_en   = busy_reg | req.wr;
        wr_addr = busy_reg ? clr_reg : req.addr[BA-1:0];
        wr_data = busy_reg ? '0 : {req.wflag, req.wsum};
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            acc_mem[wr_addr] <= wr_data;
        end
        {rflag, rsum} <= acc_mem[req.addr[BA-1:0]];
    end

endmodule

[rtl/dpb_div.sv]
// Bit-serial signed-by-unsigned divider, truncating toward zero.
// Depends on dpb_pkg.
module dpb_div
    import dpb_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [SUM_W-1:0] dividend,
    input  logic [12:0]             divisor,
    output logic                    done,
    output logic signed [SUM_W-1:0] quotient
);

    localparam logic [5:0] LAST_STEP = 6'(DIV_STEPS - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [5:0]       cnt_reg;
    logic [SUM_W-1:0] q_reg;
    logic [13:0]      rem_reg;
    logic [12:0]      dvs_reg;
    logic             neg_reg;
    logic [13:0]      rem_sh;
    logic [13:0]      diff;
    logic             ge;

    assign rem_sh   = {rem_reg[12:0], q_reg[SUM_W-1]};
    assign ge       = rem_sh >= {1'b0, dvs_reg};
    assign diff     = rem_sh - {1'b0, dvs_reg};
    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(q_reg) : $signed(q_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend[SUM_W-1] ? -dividend : dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
            neg_reg <= dividend[SUM_W-1];
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[SUM_W-2:0], ge};
            rem_reg <= ge ? diff : rem_sh;
        end
    end

endmodule

[rtl/detector_pixel_binner_top.sv]
// Map and count writes: in ST_IDLE. Sample: ST_UPD (identity) or ST_MAP then ST_UPD
// (mapped), one accumulator read-modify-write. Read: ST_UPD then ST_OUT, via ST_DIV
// when averaging a mapped bin of nonzero count (one-bit-per-cycle divider). Output
// register holds a result while the next word is taken. Reset is asynchronous,
// active low; a clearing sweep zeroes the accumulators, s_axis_tready low meanwhile.
module detector_pixel_binner_top
    import dpb_pkg::*;
#(
    parameter int PIXELS = 4096,
    parameter int BINS   = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // pixel_index, bin_number, pixel_count,
                                       // sample_value, sample_flag, zero pad
    input  logic [1:0]  s_axis_tuser,  // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // bin_value, bin_flag, read_bin, zero pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [16:0] PIX_LIM = 17'(PIXELS);
    localparam logic [16:0] BIN_LIM = 17'(BINS);

    state_t state_reg, state_next;
    logic avg_reg, idm_reg;

    logic [11:0]             in_pix, in_bn;
    logic [12:0]             in_cnt;
    logic signed [31:0]      in_val;
    logic                    in_flag;
    op_t                     in_op;
    logic                    in_fire;
    logic                    pix_ok, bn_ok, pix_bin_ok, map_bin_ok;

    op_t                     op_reg;
    logic [11:0]             bin_reg;
    logic signed [31:0]      val_reg;
    logic                    flag_reg;
    logic signed [SUM_W-1:0] res_reg;
    logic                    res_flag_reg;

    logic                    m_valid_reg, m_valid_next;
    logic [63:0]             m_data_reg;
    logic                    out_load;

    tbl_req_t                tbl_req;
    acc_req_t                acc_req;
    logic [11:0]             map_rdata;
    logic [12:0]             cnt_rdata;
    logic                    acc_busy;
    logic [SUM_W-1:0]        acc_rsum;
    logic                    acc_rflag;
    logic signed [SUM_W:0]   add_full;
    logic signed [SUM_W-1:0] add_sat;
    logic                    div_start, div_done;
    logic signed [SUM_W-1:0] div_q;

    assign in_pix  = s_axis_tdata[11:0];
    assign in_bn   = s_axis_tdata[23:12];
    assign in_cnt  = s_axis_tdata[36:24];
    assign in_val  = s_axis_tdata[68:37];
    assign in_flag = s_axis_tdata[69];
    assign in_op   = op_t'(s_axis_tuser);

    assign s_axis_tready = (state_reg == ST_IDLE) && !acc_busy;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign pix_ok     = {5'b0, in_pix} < PIX_LIM;
    assign bn_ok      = {5'b0, in_bn} < BIN_LIM;
    assign pix_bin_ok = {5'b0, in_pix} < BIN_LIM;
    assign map_bin_ok = {5'b0, map_rdata} < BIN_LIM;

    // config port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_reg <= 1'b1;
            idm_reg <= 1'b1;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (paddr)
                REG_AVG_MODE: avg_reg <= pwdata[0];
                REG_ID_MAP:   idm_reg <= pwdata[0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            REG_AVG_MODE: prdata = {31'b0, avg_reg};
            REG_ID_MAP:   prdata = {31'b0, idm_reg};
            default:      prdata = '0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (in_op)
                        OP_SAMPLE:
                        begin
                            if (pix_ok)
                            begin
                                if (!idm_reg)
                                begin
                                    state_next = ST_MAP;
                                end
                                else if (pix_bin_ok)
                                begin
                                    state_next = ST_UPD;
                                end
                            end
                        end
                        OP_READ:
                        begin
                            if (bn_ok)
                            begin
                                state_next = ST_UPD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_MAP:
            begin
                state_next = map_bin_ok ? ST_UPD : ST_IDLE;
            end
            ST_UPD:
            begin
                if (op_reg == OP_READ)
                begin
                    state_next = (avg_reg && !idm_reg && cnt_rdata != '0) ? ST_DIV : ST_OUT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        add_full = {acc_rsum[SUM_W-1], acc_rsum} + {{(SUM_W-31){val_reg[31]}}, val_reg};
        if (add_full[SUM_W] != add_full[SUM_W-1])
        begin
            add_sat = add_full[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            add_sat = add_full[SUM_W-1:0];
        end

        tbl_req.map_wr    = in_fire && (in_op == OP_MAP_WR) && pix_ok;
        tbl_req.map_addr  = {4'b0, in_pix};
        tbl_req.map_wdata = in_bn;
        tbl_req.cnt_wr    = in_fire && (in_op == OP_CNT_WR) && bn_ok;
        tbl_req.cnt_addr  = {4'b0, in_bn};
        tbl_req.cnt_wdata = in_cnt;

        acc_req.wr    = 1'b0;
        acc_req.wflag = 1'b0;
        acc_req.wsum  = '0;
        case (state_reg)
            ST_IDLE: acc_req.addr = {4'b0, (in_op == OP_SAMPLE) ? in_pix : in_bn};
            ST_MAP:  acc_req.addr = {4'b0, map_rdata};
            ST_UPD:
            begin
                acc_req.addr = {4'b0, bin_reg};
                acc_req.wr   = 1'b1;
                if (op_reg != OP_READ)
                begin
                    acc_req.wflag = acc_rflag | flag_reg;
                    acc_req.wsum  = add_sat;
                end
            end
            default: acc_req.addr = {4'b0, bin_reg};
        endcase

        div_start    = (state_reg == ST_UPD) && (state_next == ST_DIV);
        out_load     = (state_reg == ST_OUT) && (!m_valid_reg || m_axis_tready);
        m_valid_next = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg   <= in_op;
            val_reg  <= in_val;
            flag_reg <= in_flag;
            bin_reg  <= (in_op == OP_SAMPLE) ? in_pix : in_bn;
        end
        if (state_reg == ST_MAP)
        begin
            bin_reg <= map_rdata;
        end
        if (state_reg == ST_UPD)
        begin
            res_reg      <= acc_rsum;
            res_flag_reg <= acc_rflag;
        end
        if (state_reg == ST_DIV && div_done)
        begin
            res_reg <= div_q;
        end
        if (out_load)
        begin
            m_data_reg <= {3'b0, bin_reg, res_flag_reg, res_reg};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    dpb_tables #(
        .PIXELS (PIXELS),
        .BINS   (BINS)
    ) u_tables (
        .clk       (clk),
        .req       (tbl_req),
        .map_rdata (map_rdata),
        .cnt_rdata (cnt_rdata)
    );

    dpb_accum #(
        .BINS (BINS)
    ) u_accum (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (acc_req),
        .busy  (acc_busy),
        .rsum  (acc_rsum),
        .rflag (acc_rflag)
    );

    dpb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_rsum),
        .divisor  (cnt_rdata),
        .done     (div_done),
        .quotient (div_q)
    );

endmodule

[rtl/dpb_checker.sv]
// Port-level checks for the detector pixel binner, bound to the top level.
// Depends on dpb_pkg and detector_pixel_binner_top_macros.svh.
`include "detector_pixel_binner_top_macros.svh"

module dpb_checker
    import dpb_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        pready
);

    `DPB_ASSERT_RST(a_clear_after_reset, !rst_n |=> !s_axis_tready, "word taken during clearing")
    `DPB_ASSERT(a_no_result_from_write, (s_axis_tvalid && s_axis_tready && s_axis_tuser != OP_READ) |=> !$rose(m_axis_tvalid), "result without read")
    `DPB_ASSERT(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)), "stalled result changed")
    `DPB_ASSERT(a_pad_zero, m_axis_tvalid |-> (m_axis_tdata[63:61] == 3'b0), "nonzero pad")
    `DPB_ASSERT(a_pready, pready, "pready low")

endmodule

bind detector_pixel_binner_top dpb_checker u_dpb_checker (.*);

[bench/detector_pixel_binner_checker.sv]
// Checker for the detector pixel binner: watches the word channels and APB writes,
// predicts each bin result and compares it. Depends on dpb_pkg.
`timescale 1ns / 100ps

module detector_pixel_binner_checker
    import dpb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fails,
    output int          pending
);

    typedef struct packed {
        logic [47:0] value;
        logic        flag;
        logic [11:0] bin;
    } bin_result_t;

    logic              average_on;
    logic              identity_on;
    logic [11:0]       pixel_to_bin [4096];
    logic [12:0]       pixels_in_bin [4096];
    logic signed [47:0] bin_acc [4096];
    logic              bin_or [4096];
    bin_result_t       bin_results_due [$];

    initial begin
        fails   = 0;
        pending = 0;
        foreach (pixel_to_bin[i]) pixel_to_bin[i] = '0;
        foreach (pixels_in_bin[i]) pixels_in_bin[i] = '0;
    end

    task automatic report(string what, logic [47:0] want, logic [47:0] got);
        if (fails < 10)
            $display("mismatch %s: expected %h, got %h", what, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        op_t                op;
        logic [11:0]        pix;
        logic [11:0]        bn;
        logic [12:0]        cnt;
        logic signed [31:0] val;
        logic               flg;
        logic [11:0]        b;
        longint             sum;
        longint             div;
        bin_result_t        want;
        bin_result_t        got;
        logic               bad;
        if (!rst_n)
        begin
            average_on  = 1'b1;
            identity_on = 1'b1;
            foreach (bin_acc[i])
            begin
                bin_acc[i] = '0;
                bin_or[i]  = 1'b0;
            end
            bin_results_due.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == REG_AVG_MODE)
                    average_on = pwdata[0];
                else if (paddr == REG_ID_MAP)
                    identity_on = pwdata[0];
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = '{m_axis_tdata[47:0], m_axis_tdata[48], m_axis_tdata[60:49]};
                if (bin_results_due.size() == 0)
                begin
                    if (fails < 10)
                        $display("unexpected bin word %h", m_axis_tdata);
                    fails++;
                end
                else
                begin
                    want = bin_results_due.pop_front();
                    bad  = 1'b0;
                    if (got.value !== want.value)
                    begin
                        report("bin_value", want.value, got.value);
                        bad = 1'b1;
                    end
                    if (got.flag !== want.flag)
                    begin
                        report("bin_flag", want.flag, got.flag);
                        bad = 1'b1;
                    end
                    if (got.bin !== want.bin)
                    begin
                        report("read_bin", want.bin, got.bin);
                        bad = 1'b1;
                    end
                    if (bad)
                        fails++;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                op  = op_t'(s_axis_tuser);
                pix = s_axis_tdata[11:0];
                bn  = s_axis_tdata[23:12];
                cnt = s_axis_tdata[36:24];
                val = s_axis_tdata[68:37];
                flg = s_axis_tdata[69];
                case (op)
                    OP_MAP_WR: pixel_to_bin[pix] = bn;
                    OP_CNT_WR: pixels_in_bin[bn] = cnt;
                    OP_SAMPLE:
                    begin
                        b   = identity_on ? pix : pixel_to_bin[pix];
                        sum = longint'(bin_acc[b]) + longint'(val);
                        if (sum > longint'(SUM_MAX))
                            sum = longint'(SUM_MAX);
                        if (sum < longint'(SUM_MIN))
                            sum = longint'(SUM_MIN);
                        bin_acc[b] = sum[47:0];
                        bin_or[b]  = bin_or[b] | flg;
                    end
                    default:
                    begin
                        sum = longint'(bin_acc[bn]);
                        if (average_on)
                        begin
                            div = identity_on ? 1 : longint'(pixels_in_bin[bn]);
                            if (div != 0)
                                sum = sum / div;
                        end
                        bin_results_due.push_back('{sum[47:0], bin_or[bn], bn});
                        bin_acc[bn] = '0;
                        bin_or[bn]  = 1'b0;
                    end
                endcase
            end
        end
        pending = bin_results_due.size();
    end

endmodule

[bench/detector_pixel_binner_top_test.sv]
// Testbench top for detector_pixel_binner_top: directed and random words, APB
// register changes, random idling on both sides. Depends on dpb_pkg and the checker.
`timescale 1ns / 100ps

module detector_pixel_binner_top_test;
    import dpb_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE      = 60;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fails;
    int          pending;
    int          cycles = 0;
    int          burst_left = 0;
    int          stall_left = 0;
    int          stall_mode = 0;

    logic        map_known [4096];
    logic        count_known [4096];
    logic [11:0] mapped_pixels [$];
    logic [11:0] counted_bins [$];

    always #1 clk = ~clk;

    detector_pixel_binner_top dut (.*);

    detector_pixel_binner_checker checker_i (.*);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("detector_pixel_binner_top_test NOT OK");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(5, 120);
        end
        stall_left--;
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= ($urandom_range(0, 7) == 0);
            default: m_axis_tready <= 1'b0;
        endcase
    end

    task automatic send_word(op_t op, logic [11:0] pix, logic [11:0] bn, logic [12:0] cnt,
                             logic [31:0] val, logic flg);
        logic ok;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {2'b00, flg, val, cnt, bn, pix};
        if (op == OP_MAP_WR && !map_known[pix])
        begin
            map_known[pix] = 1'b1;
            mapped_pixels.push_back(pix);
        end
        if (op == OP_CNT_WR && !count_known[bn])
        begin
            count_known[bn] = 1'b1;
            counted_bins.push_back(bn);
        end
        forever
        begin
            @(negedge clk);
            ok = s_axis_tready;
            @(posedge clk);
            if (ok)
                break;
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {31'b0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(negedge clk);
        while (!pready);
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 32'h7fffffff;
            1:       return 32'h80000000;
            2:       return $urandom_range(0, 2000) - 1000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [11:0] pick_bin();
        if ($urandom_range(0, 4) == 0)
            return 12'($urandom_range(0, 4095));
        return 12'($urandom_range(0, 31));
    endfunction

    task automatic random_words(int n, logic avg, logic idm);
        int   k;
        int   op_roll;
        logic [12:0] cnt;
        logic [11:0] bn;
        for (k = 0; k < n; k++)
        begin
            op_roll = $urandom_range(0, 99);
            cnt = ($urandom_range(0, 3) == 0) ? 13'($urandom_range(0, 8191))
                                              : 13'($urandom_range(1, 16));
            if (op_roll < 15 || (!idm && mapped_pixels.size() == 0 && op_roll < 75))
                send_word(OP_MAP_WR, 12'($urandom), pick_bin(), 13'($urandom), $urandom,
                          1'($urandom));
            else if (op_roll < 25)
                send_word(OP_CNT_WR, 12'($urandom), pick_bin(), cnt, $urandom,
                          1'($urandom));
            else if (op_roll < 75)
            begin
                if (idm)
                    send_word(OP_SAMPLE, pick_bin(), 12'($urandom), 13'($urandom),
                              pick_value(), 1'($urandom));
                else
                    send_word(OP_SAMPLE,
                              mapped_pixels[$urandom_range(0, mapped_pixels.size() - 1)],
                              12'($urandom), 13'($urandom), pick_value(), 1'($urandom));
            end
            else
            begin
                bn = pick_bin();
                if (avg && !idm)
                begin
                    if (counted_bins.size() == 0)
                        continue;
                    bn = counted_bins[$urandom_range(0, counted_bins.size() - 1)];
                end
                send_word(OP_READ, 12'($urandom), bn, 13'($urandom), $urandom,
                          1'($urandom));
            end
        end
        drain();
    endtask

    initial
    begin
        foreach (map_known[i])
        begin
            map_known[i]   = 1'b0;
            count_known[i] = 1'b0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identity map, averaging with unit count
        send_word(OP_SAMPLE, 12'd0, 12'd0, 13'd0, 32'h7fffffff, 1'b1);
        send_word(OP_SAMPLE, 12'd4095, 12'hfff, 13'h1fff, 32'h80000000, 1'b0);
        send_word(OP_SAMPLE, 12'd7, 12'd0, 13'd0, 32'hfffffffd, 1'b0);
        send_word(OP_SAMPLE, 12'd7, 12'd0, 13'd0, 32'hfffffffd, 1'b1);
        send_word(OP_READ, 12'd0, 12'd0, 13'd0, 32'd0, 1'b0);
        send_word(OP_READ, 12'd0, 12'd4095, 13'd0, 32'd0, 1'b0);
        send_word(OP_READ, 12'd0, 12'd7, 13'd0, 32'd0, 1'b0);
        send_word(OP_READ, 12'd0, 12'd5, 13'd0, 32'd0, 1'b0);
        send_word(OP_MAP_WR, 12'd0, 12'd4095, 13'd0, 32'd0, 1'b0);
        send_word(OP_MAP_WR, 12'd4095, 12'd0, 13'd0, 32'd0, 1'b0);
        send_word(OP_CNT_WR, 12'd0, 12'd0, 13'd0, 32'd0, 1'b0);
        send_word(OP_CNT_WR, 12'd0, 12'd4095, 13'h1fff, 32'd0, 1'b0);
        send_word(OP_CNT_WR, 12'd0, 12'd3, 13'd4096, 32'd0, 1'b0);
        send_word(OP_CNT_WR, 12'd0, 12'd9, 13'd3, 32'd0, 1'b0);
        drain();

        // mapped bins: large count, zero count, negative truncation
        write_reg(REG_ID_MAP, 1'b0);
        send_word(OP_MAP_WR, 12'd1, 12'd3, 13'd0, 32'd0, 1'b0);
        send_word(OP_MAP_WR, 12'd2, 12'd3, 13'd0, 32'd0, 1'b0);
        send_word(OP_MAP_WR, 12'd10, 12'd0, 13'd0, 32'd0, 1'b0);
        send_word(OP_MAP_WR, 12'd11, 12'd9, 13'd0, 32'd0, 1'b0);
        send_word(OP_SAMPLE, 12'd1, 12'd0, 13'd0, 32'h7fffffff, 1'b0);
        send_word(OP_SAMPLE, 12'd2, 12'd0, 13'd0, 32'h00123456, 1'b1);
        send_word(OP_SAMPLE, 12'd10, 12'd0, 13'd0, 32'hffff0000, 1'b0);
        send_word(OP_SAMPLE, 12'd11, 12'd0, 13'd0, 32'hfffffff9, 1'b1);
        send_word(OP_SAMPLE, 12'd4095, 12'd0, 13'd0, 32'd5, 1'b1);
        send_word(OP_READ, 12'd0, 12'd3, 13'd0, 32'd0, 1'b0);
        send_word(OP_READ, 12'd0, 12'd0, 13'd0, 32'd0, 1'b0);
        send_word(OP_READ, 12'd0, 12'd9, 13'd0, 32'd0, 1'b0);
        drain();

        write_reg(REG_AVG_MODE, 1'b0);
        write_reg(REG_ID_MAP, 1'b1);

        random_words(350, 1'b0, 1'b1);
        write_reg(REG_ID_MAP, 1'b0);
        random_words(350, 1'b0, 1'b0);
        write_reg(REG_AVG_MODE, 1'b1);
        random_words(350, 1'b1, 1'b0);
        write_reg(REG_ID_MAP, 1'b1);
        random_words(350, 1'b1, 1'b1);

        if (fails == 0)
            $display("detector_pixel_binner_top_test OK");
        else
            $display("detector_pixel_binner_top_test NOT OK");
        $finish;
    end

endmodule
